/* sv/assert_macros.svh */
// Assertion helpers for the command line parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property check: holds on every clock edge outside reset.
`define CLSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Forbidden condition: the expression must never be true.
`define CLSP_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define CLSP_ASSERT(lbl, clk, rst, prop, msg)
`define CLSP_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* sv/clsp_pkg.sv */
package clsp_pkg;

  localparam int CHAR_W    = 8;
  localparam int KIND_W    = 3;
  localparam int NAME_W    = 64;
  localparam int LEN_W     = 16;
  localparam int NCOUNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = 16;

  localparam int DEF_PREFIX_CAP   = 8;
  localparam int DEF_COMMAND_CAP  = 8;
  localparam int DEF_PARAM_CAP    = 16;
  localparam int DEF_VALUE_CAP    = 24;
  localparam int DEF_MAX_COMMANDS = 4;

  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] END_CHAR_RST = 8'h0A;

  // output item kinds
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PREFIX  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CMD     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PARAM   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_VALUE   = 3'd4;

  // configuration register indexes (names occupy 0..3)
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic step;        // parse the incoming byte
    logic emit_start;  // end byte taken: hold it, rewind the cursor
    logic emit_load;   // load the cursor item into the output register
    logic resume;      // restart and parse the held byte from begin
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_end;      // incoming byte equals the end character
    logic emit_last;   // cursor sits on the final item of the run
  } stat_t;

endpackage

/* sv/clsp_ctrl.sv */
`include "assert_macros.svh"

module clsp_ctrl
  import clsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;
  logic slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd.step       = accept && !stat.is_end;
    cmd.emit_start = accept && stat.is_end;
    cmd.emit_load  = (state == S_EMIT) && slot_free;
    cmd.resume     = cmd.emit_load && stat.emit_last;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.emit_start) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.resume) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `CLSP_NEVER(a_no_overwrite, clk, rst, cmd.emit_load && out_valid && !out_ready, "held result overwritten")
  `CLSP_ASSERT(a_run_end, clk, rst, cmd.resume |=> (state == S_IDLE) && out_valid, "run end lost")
  `CLSP_ASSERT(a_stall_in, clk, rst, cmd.emit_start |=> !in_ready, "input taken during run")

endmodule

/* sv/clsp_datapath.sv */
`include "assert_macros.svh"

module clsp_datapath
  import clsp_pkg::*;
#(
  parameter int PREFIX_CAP   = DEF_PREFIX_CAP,
  parameter int COMMAND_CAP  = DEF_COMMAND_CAP,
  parameter int PARAM_CAP    = DEF_PARAM_CAP,
  parameter int VALUE_CAP    = DEF_VALUE_CAP,
  parameter int MAX_COMMANDS = DEF_MAX_COMMANDS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NAME_W-1:0]    cfg_data,
  input  logic [CHAR_W-1:0]    in_byte,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic [KIND_W-1:0]    out_kind,
  output logic [CHAR_W-1:0]    out_char,
  output logic                 out_status,
  output logic                 out_last
);

  localparam int PCW = $clog2(PREFIX_CAP + 1);
  localparam int CCW = $clog2(COMMAND_CAP + 1);
  localparam int RCW = $clog2(PARAM_CAP + 1);
  localparam int VCW = $clog2(VALUE_CAP + 1);
  localparam int PAW = (PREFIX_CAP > 1) ? $clog2(PREFIX_CAP) : 1;
  localparam int CAW = $clog2(COMMAND_CAP);
  localparam int RAW = (PARAM_CAP > 1) ? $clog2(PARAM_CAP) : 1;
  localparam int VAW = (VALUE_CAP > 1) ? $clog2(VALUE_CAP) : 1;
  localparam int MAX_PC = (PREFIX_CAP > COMMAND_CAP) ? PREFIX_CAP : COMMAND_CAP;
  localparam int MAX_RV = (PARAM_CAP > VALUE_CAP) ? PARAM_CAP : VALUE_CAP;
  localparam int MAXCAP = (MAX_PC > MAX_RV) ? MAX_PC : MAX_RV;
  localparam int IW  = $clog2(MAXCAP);
  localparam int NMW = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;

  localparam logic [2:0] MODE_BEGIN  = 3'd0;
  localparam logic [2:0] MODE_PREFIX = 3'd1;
  localparam logic [2:0] MODE_CMD    = 3'd2;
  localparam logic [2:0] MODE_SPLIT  = 3'd3;
  localparam logic [2:0] MODE_PARAM  = 3'd4;
  localparam logic [2:0] MODE_VALUE  = 3'd5;

  // character k of a name, zero past its length
  function automatic logic [CHAR_W-1:0] name_char(logic [NAME_W-1:0] nm,
                                                 logic [3:0] len, int k);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (k < 8 && 4'(k) < len) c = nm[CHAR_W*k +: CHAR_W];
    return c;
  endfunction

  // configuration
  logic [NAME_W-1:0]   names [MAX_COMMANDS];
  logic [LEN_W-1:0]    lengths;
  logic [NCOUNT_W-1:0] ncount;
  logic [CHAR_W-1:0]   end_char;
  logic [NCOUNT_W-1:0] active_n;

  // parse state
  logic [2:0]        mode, mode_next;
  logic [PCW-1:0]    pc, pc_next;
  logic [CCW-1:0]    cc, cc_next;
  logic [RCW-1:0]    rc, rc_next;
  logic [VCW-1:0]    vc, vc_next;
  logic [CHAR_W-1:0] pstore [PREFIX_CAP];
  logic [CHAR_W-1:0] cstore [COMMAND_CAP];
  logic [CHAR_W-1:0] rstore [PARAM_CAP];
  logic [CHAR_W-1:0] vstore [VALUE_CAP];
  logic [CHAR_W-1:0] held;

  // step datapath
  logic              do_step;
  logic [CHAR_W-1:0] sb;
  logic [2:0]        e_mode;
  logic [PCW-1:0]    e_pc;
  logic [CCW-1:0]    e_cc;
  logic [RCW-1:0]    e_rc;
  logic [VCW-1:0]    e_vc;
  logic [CCW-1:0]    cnt1;
  logic [CHAR_W-1:0] typed [COMMAND_CAP];
  logic [MAX_COMMANDS-1:0] same_vec;
  logic              first_hit;
  logic              found;
  logic              name_done;
  logic              restart;
  logic              p_we, c_we, r_we, v_we;
  logic [CAW-1:0]    c_wa;

  // emit cursor
  logic [KIND_W-1:0] cur_kind, nxt_kind;
  logic [IW-1:0]     cur_idx;
  logic [IW:0]       cnt_ext;
  logic              more;
  logic              last;
  logic [CHAR_W-1:0] char_sel;
  logic              line_status;

  assign active_n = (ncount > NCOUNT_W'(MAX_COMMANDS)) ? NCOUNT_W'(MAX_COMMANDS) : ncount;
  assign stat.is_end = (in_byte == end_char);

  // a resumed byte sees the state right after a restart
  assign do_step = cmd.step || cmd.resume;
  assign sb      = cmd.resume ? held : in_byte;
  assign e_mode  = cmd.resume ? MODE_BEGIN : mode;
  assign e_pc    = cmd.resume ? '0 : pc;
  assign e_cc    = cmd.resume ? '0 : cc;
  assign e_rc    = cmd.resume ? '0 : rc;
  assign e_vc    = cmd.resume ? '0 : vc;
  assign cnt1    = e_cc + CCW'(1);

  always_comb begin
    for (int k = 0; k < COMMAND_CAP; k++) begin
      typed[k] = (CCW'(k) == e_cc) ? sb : cstore[k];
    end
  end

  // prefix compare of every table entry against the typed name
  always_comb begin
    for (int i = 0; i < MAX_COMMANDS; i++) begin
      same_vec[i] = 1'b1;
      for (int k = 0; k < COMMAND_CAP; k++) begin
        if (CCW'(k) < cnt1 &&
            typed[k] != name_char(names[i], lengths[4*i +: 4], k)) begin
          same_vec[i] = 1'b0;
        end
      end
    end
  end

  // first table entry wins
  always_comb begin
    first_hit = 1'b0;
    found     = 1'b0;
    name_done = 1'b0;
    for (int i = 0; i < MAX_COMMANDS; i++) begin
      if (NCOUNT_W'(i) < active_n) begin
        if (name_char(names[i], lengths[4*i +: 4], 0) == sb) first_hit = 1'b1;
        if (!found && same_vec[i]) begin
          found     = 1'b1;
          name_done = (5'(cnt1) == 5'(lengths[4*i +: 4]));
        end
      end
    end
  end

  always_comb begin
    mode_next = e_mode;
    pc_next   = e_pc;
    cc_next   = e_cc;
    rc_next   = e_rc;
    vc_next   = e_vc;
    restart   = 1'b0;
    p_we      = 1'b0;
    c_we      = 1'b0;
    r_we      = 1'b0;
    v_we      = 1'b0;
    c_wa      = e_cc[CAW-1:0];
    if (do_step) begin
      case (e_mode)
        MODE_BEGIN: begin
          if (sb == CHAR_PERCENT) begin
            mode_next = MODE_PREFIX;
          end else if (first_hit) begin
            mode_next = MODE_CMD;
            c_we      = 1'b1;
            c_wa      = '0;
            cc_next   = CCW'(1);
          end
        end
        MODE_PREFIX: begin
          if (sb == CHAR_PERCENT) begin
            mode_next = MODE_BEGIN;
          end else if (e_pc >= PCW'(PREFIX_CAP)) begin
            restart = 1'b1;
          end else begin
            p_we    = 1'b1;
            pc_next = e_pc + PCW'(1);
          end
        end
        MODE_CMD: begin
          if (e_cc >= CCW'(COMMAND_CAP)) begin
            restart = 1'b1;
          end else begin
            c_we    = 1'b1;
            cc_next = cnt1;
            if (!found) begin
              restart = 1'b1;
            end else if (name_done) begin
              mode_next = MODE_SPLIT;
            end
          end
        end
        MODE_SPLIT: begin
          if (sb == CHAR_COMMA) mode_next = MODE_PARAM;
          else restart = 1'b1;
        end
        MODE_PARAM: begin
          if (e_rc >= RCW'(PARAM_CAP)) begin
            restart = 1'b1;
          end else if (sb == CHAR_COMMA) begin
            mode_next = MODE_VALUE;
          end else begin
            r_we    = 1'b1;
            rc_next = e_rc + RCW'(1);
          end
        end
        MODE_VALUE: begin
          if (e_vc >= VCW'(VALUE_CAP)) begin
            restart = 1'b1;
          end else begin
            v_we    = 1'b1;
            vc_next = e_vc + VCW'(1);
          end
        end
        default: restart = 1'b1;
      endcase
    end
    if (restart) begin
      mode_next = MODE_BEGIN;
      pc_next   = '0;
      cc_next   = '0;
      rc_next   = '0;
      vc_next   = '0;
    end
  end

  // walk: summary, prefix, command, param, value; empty groups skipped
  always_comb begin
    case (cur_kind)
      KIND_PREFIX: cnt_ext = (IW+1)'(pc);
      KIND_CMD:    cnt_ext = (IW+1)'(cc);
      KIND_PARAM:  cnt_ext = (IW+1)'(rc);
      KIND_VALUE:  cnt_ext = (IW+1)'(vc);
      default:     cnt_ext = '0;
    endcase
    more     = (cur_kind != KIND_SUMMARY) && (({1'b0, cur_idx} + (IW+1)'(1)) < cnt_ext);
    nxt_kind = cur_kind;
    last     = 1'b0;
    if (!more) begin
      if (cur_kind == KIND_SUMMARY && pc != '0) begin
        nxt_kind = KIND_PREFIX;
      end else if (cur_kind <= KIND_PREFIX && cc != '0) begin
        nxt_kind = KIND_CMD;
      end else if (cur_kind <= KIND_CMD && rc != '0) begin
        nxt_kind = KIND_PARAM;
      end else if (cur_kind <= KIND_PARAM && vc != '0) begin
        nxt_kind = KIND_VALUE;
      end else begin
        last = 1'b1;
      end
    end
  end

  assign stat.emit_last = last;

  always_comb begin
    case (cur_kind)
      KIND_PREFIX: char_sel = pstore[cur_idx[PAW-1:0]];
      KIND_CMD:    char_sel = cstore[cur_idx[CAW-1:0]];
      KIND_PARAM:  char_sel = rstore[cur_idx[RAW-1:0]];
      KIND_VALUE:  char_sel = vstore[cur_idx[VAW-1:0]];
      default:     char_sel = '0;
    endcase
    if (mode inside {MODE_SPLIT, MODE_PARAM, MODE_VALUE}) begin
      line_status = 1'b0;
    end else if (mode == MODE_BEGIN) begin
      line_status = (pc == '0);
    end else begin
      line_status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COMMANDS; i++) names[i] <= '0;
      lengths  <= '0;
      ncount   <= NCOUNT_W'(1);
      end_char <= END_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTHS:  lengths  <= cfg_data[LEN_W-1:0];
        CFG_COUNT:    ncount   <= cfg_data[NCOUNT_W-1:0];
        CFG_END_CHAR: end_char <= cfg_data[CHAR_W-1:0];
        default: begin
          if (cfg_index < CFG_IDX_W'(MAX_COMMANDS)) names[cfg_index[NMW-1:0]] <= cfg_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_BEGIN;
      pc       <= '0;
      cc       <= '0;
      rc       <= '0;
      vc       <= '0;
      cur_kind <= KIND_SUMMARY;
      cur_idx  <= '0;
    end else begin
      mode <= mode_next;
      pc   <= pc_next;
      cc   <= cc_next;
      rc   <= rc_next;
      vc   <= vc_next;
      if (cmd.emit_start) begin
        cur_kind <= KIND_SUMMARY;
        cur_idx  <= '0;
      end else if (cmd.emit_load && !last) begin
        cur_kind <= nxt_kind;
        cur_idx  <= more ? cur_idx + IW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) pstore[e_pc[PAW-1:0]] <= sb;
    if (c_we) cstore[c_wa] <= sb;
    if (r_we) rstore[e_rc[RAW-1:0]] <= sb;
    if (v_we) vstore[e_vc[VAW-1:0]] <= sb;
    if (cmd.emit_start) held <= in_byte;
    if (cmd.emit_load) begin
      out_kind   <= cur_kind;
      out_char   <= char_sel;
      out_status <= (cur_kind == KIND_SUMMARY) ? line_status : 1'b0;
      out_last   <= last;
    end
  end

  `CLSP_NEVER(a_caps, clk, rst, (pc > PCW'(PREFIX_CAP)) || (cc > CCW'(COMMAND_CAP)) || (rc > RCW'(PARAM_CAP)) || (vc > VCW'(VALUE_CAP)), "store count past capacity")
  `CLSP_ASSERT(a_split_name, clk, rst, (mode == MODE_SPLIT) |-> (cc >= CCW'(2)), "split without a full name")

endmodule

/* sv/command_line_stream_parser_unit.sv */
// Command line stream parser. One byte enters per transaction on the s_axis side and
// is parsed as [%prefix%]name[,param][,value]<end>; names are matched by prefix
// against a table of up to four configured names, and a bad name, a missing comma
// or a full field quietly restarts the line. Ordinary bytes leave the input ready for
// the next byte on the next cycle. An end byte starts a run on m_axis:
// a summary transaction (status 0 ok, 1 line not complete) followed by one
// transaction per stored prefix, command, param and value character, tlast on the
// final one. The run is 1 + stored characters transactions (at most
// 1 + PREFIX_CAP + COMMAND_CAP + PARAM_CAP + VALUE_CAP, 57 by default), paced by
// the single output register that is loaded with one item per cycle unless m_axis
// backpressure holds it; s_axis_tready stays low from the cycle after the
// end byte until the final item is loaded. The end byte is then parsed again as
// the possible first character of a new line. Configuration writes are taken on
// any cycle (cfg_ready is always high) and should be made between lines.
module command_line_stream_parser_unit
  import clsp_pkg::*;
#(
  parameter int PREFIX_CAP   = DEF_PREFIX_CAP,
  parameter int COMMAND_CAP  = DEF_COMMAND_CAP,
  parameter int PARAM_CAP    = DEF_PARAM_CAP,
  parameter int VALUE_CAP    = DEF_VALUE_CAP,
  parameter int MAX_COMMANDS = DEF_MAX_COMMANDS
) (
  input  logic                 clk,
  input  logic                 rst,
  // input byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] in_byte
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,   // [7:0] out_char, [8] status, rest zero
  output logic [KIND_W-1:0]    m_axis_tuser,   // [2:0] item_kind
  output logic                 m_axis_tlast,   // run_last
  // configuration writes: 0..3 names, 4 lengths, 5 count, 6 end char
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NAME_W-1:0]    cfg_data
);

  cmd_t              cmd;
  stat_t             stat;
  logic [CHAR_W-1:0] out_char;
  logic              out_status;

  assign cfg_ready = 1'b1;

  // sequencer: byte intake vs. completion run, owns the output valid
  clsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // parse state, character stores, name table, emit cursor, output payload
  clsp_datapath #(
    .PREFIX_CAP   (PREFIX_CAP),
    .COMMAND_CAP  (COMMAND_CAP),
    .PARAM_CAP    (PARAM_CAP),
    .VALUE_CAP    (VALUE_CAP),
    .MAX_COMMANDS (MAX_COMMANDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_kind   (m_axis_tuser),
    .out_char   (out_char),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_W - CHAR_W - 1)'(0), out_status, out_char};

endmodule

/* sim/command_line_stream_parser_unit_tb.sv */
`default_nettype none

module command_line_stream_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clsp_pkg::*;

  // name table registers; the others come from the package
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int RANDOM_PER_PHASE = 5;      // minimum input bytes per random phase
  localparam int SETTLE_CYCLES    = 16;     // re-parse of the end byte, with margin
  localparam int RX_HOLD_CYCLES   = 300;    // long m_axis hold-off
  localparam int TIMEOUT_NS       = 2_000_000;

  typedef enum logic [2:0] {
    PM_BEGIN, PM_PREFIX, PM_NAME, PM_SPLIT, PM_PARAM, PM_VALUE
  } parse_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              status;
    logic              last;
  } line_item_t;

  // Tracks the parse of the byte stream and holds the items each end byte releases.
  class line_tracker;
    logic [NAME_W-1:0]   names [4];
    logic [LEN_W-1:0]    name_lens;
    logic [NCOUNT_W-1:0] name_total;
    logic [CHAR_W-1:0]   terminator;

    parse_mode_t      mode;
    logic [CHAR_W-1:0] prefix_buf [DEF_PREFIX_CAP];
    logic [CHAR_W-1:0] typed_buf  [DEF_COMMAND_CAP];
    logic [CHAR_W-1:0] param_buf  [DEF_PARAM_CAP];
    logic [CHAR_W-1:0] value_buf  [DEF_VALUE_CAP];
    int prefix_len, typed_len, param_len, value_len;

    line_item_t due_items [$];
    int errors;

    function new();
      foreach (names[i]) names[i] = '0;
      name_lens  = '0;
      name_total = 3'd1;
      terminator = END_CHAR_RST;
      errors     = 0;
      restart_line();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NAME_W-1:0] data);
      case (idx)
        CFG_NAME_0, CFG_NAME_1, CFG_NAME_2, CFG_NAME_3: names[idx[1:0]] = data;
        CFG_LENGTHS:  name_lens  = data[LEN_W-1:0];
        CFG_COUNT:    name_total = data[NCOUNT_W-1:0];
        CFG_END_CHAR: terminator = data[CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    function void restart_line();
      mode       = PM_BEGIN;
      prefix_len = 0;
      typed_len  = 0;
      param_len  = 0;
      value_len  = 0;
    endfunction

    // count register saturates at the table size
    function int table_size();
      return (name_total > DEF_MAX_COMMANDS) ? DEF_MAX_COMMANDS : int'(name_total);
    endfunction

    function int name_length(int i);
      return int'(name_lens[4*i +: 4]);
    endfunction

    function logic [CHAR_W-1:0] name_byte(int i, int k);
      if (k >= 8 || k >= name_length(i)) return '0;
      return names[i][8*k +: 8];
    endfunction

    function void add_item(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch, logic st,
                           logic last);
      line_item_t it;
      it.kind   = kind;
      it.ch     = ch;
      it.status = st;
      it.last   = last;
      due_items.push_back(it);
    endfunction

    // end byte: summary, then every stored character, last mark on the final one
    function void close_line();
      logic st;
      int   total, seq;
      case (mode)
        PM_SPLIT, PM_PARAM, PM_VALUE: st = 1'b0;
        PM_BEGIN:                     st = (prefix_len == 0);
        default:                      st = 1'b1;
      endcase
      total = 1 + prefix_len + typed_len + param_len + value_len;
      add_item(KIND_SUMMARY, '0, st, total == 1);
      seq = 1;
      for (int k = 0; k < prefix_len; k++) begin
        add_item(KIND_PREFIX, prefix_buf[k], 1'b0, seq == total - 1);
        seq++;
      end
      for (int k = 0; k < typed_len; k++) begin
        add_item(KIND_CMD, typed_buf[k], 1'b0, seq == total - 1);
        seq++;
      end
      for (int k = 0; k < param_len; k++) begin
        add_item(KIND_PARAM, param_buf[k], 1'b0, seq == total - 1);
        seq++;
      end
      for (int k = 0; k < value_len; k++) begin
        add_item(KIND_VALUE, value_buf[k], 1'b0, seq == total - 1);
        seq++;
      end
      restart_line();
    endfunction

    // prefix match against the table; the first matching entry decides
    function void name_char(logic [CHAR_W-1:0] b);
      bit found, same;
      if (typed_len >= DEF_COMMAND_CAP) begin
        restart_line();
        return;
      end
      typed_buf[typed_len] = b;
      typed_len++;
      found = 1'b0;
      for (int i = 0; i < table_size() && !found; i++) begin
        same = 1'b1;
        for (int k = 0; k < typed_len; k++)
          if (typed_buf[k] != name_byte(i, k)) same = 1'b0;
        if (same) begin
          found = 1'b1;
          if (typed_len == name_length(i)) mode = PM_SPLIT;
        end
      end
      if (!found) restart_line();
    endfunction

    function void take_byte(logic [CHAR_W-1:0] b);
      if (b == terminator) close_line();
      // the end byte falls through and is parsed again from begin
      case (mode)
        PM_BEGIN: begin
          if (b == CHAR_PERCENT) begin
            mode = PM_PREFIX;
          end else begin
            for (int i = 0; i < table_size() && mode == PM_BEGIN; i++) begin
              if (name_byte(i, 0) == b) begin
                mode         = PM_NAME;
                typed_buf[0] = b;
                typed_len    = 1;
              end
            end
          end
        end
        PM_PREFIX: begin
          if (b == CHAR_PERCENT) mode = PM_BEGIN;
          else if (prefix_len >= DEF_PREFIX_CAP) restart_line();
          else prefix_buf[prefix_len++] = b;
        end
        PM_NAME: name_char(b);
        PM_SPLIT: begin
          if (b == CHAR_COMMA) mode = PM_PARAM;
          else restart_line();
        end
        PM_PARAM: begin
          // a full param field restarts even on a comma
          if (param_len >= DEF_PARAM_CAP) restart_line();
          else if (b == CHAR_COMMA) mode = PM_VALUE;
          else param_buf[param_len++] = b;
        end
        PM_VALUE: begin
          if (value_len >= DEF_VALUE_CAP) restart_line();
          else value_buf[value_len++] = b;
        end
        default: restart_line();
      endcase
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    task match_item(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch, logic st, logic last,
                    logic [TDATA_W-CHAR_W-2:0] pad);
      line_item_t want;
      if (due_items.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction kind %0d char %02h", kind, ch));
        return;
      end
      want = due_items.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (ch !== want.ch)
        report_mismatch($sformatf("char %02h, expected %02h", ch, want.ch));
      if (st !== want.status)
        report_mismatch($sformatf("status %b, expected %b", st, want.status));
      if (last !== want.last)
        report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
      if (pad !== '0)
        report_mismatch($sformatf("tdata padding %h not zero", pad));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [CHAR_W-1:0]    s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NAME_W-1:0]    cfg_data;

  line_tracker  lines;
  logic [7:0]   line_q [$];
  int           bytes_sent;
  int           send_idle_pct, recv_idle_pct;
  logic         hold_arm, rx_hold;
  logic [63:0]  rand_names [4];

  command_line_stream_parser_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random tready, forced low during the hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long hold-off on m_axis while the sender keeps offering bytes
  initial begin
    rx_hold = 1'b0;
    wait (hold_arm);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      lines.match_item(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast,
                       m_axis_tdata[TDATA_W-1:9]);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("command_line_stream_parser_unit_tb: errors");
    $finish;
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // one s_axis transaction, with random gaps before it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk); while (!s_axis_tready);
    lines.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic send_run(input logic [7:0] c, input int n);
    repeat (n) send_byte(c);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [NAME_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    lines.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_table(input logic [63:0] n0, input logic [63:0] n1,
                             input logic [63:0] n2, input logic [63:0] n3,
                             input logic [15:0] lens, input logic [2:0] count,
                             input logic [7:0] term);
    write_cfg(CFG_NAME_0, n0);
    write_cfg(CFG_NAME_1, n1);
    write_cfg(CFG_NAME_2, n2);
    write_cfg(CFG_NAME_3, n3);
    write_cfg(CFG_LENGTHS, 64'(lens));
    write_cfg(CFG_COUNT, 64'(count));
    write_cfg(CFG_END_CHAR, 64'(term));
  endtask

  // all results in, then a settle wait for the end byte to be parsed again
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (lines.due_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_name(input string s);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < s.len() && k < 8; k++) v[8*k +: 8] = s[k];
    return v;
  endfunction

  // mostly short fields, sometimes full, sometimes one over
  function automatic int field_len(input int cap);
    int r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(3);
    if (r < 8) return $urandom_range(cap);
    if (r == 8) return cap;
    return cap + 1;
  endfunction

  function automatic logic [7:0] text_char(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == a || c == b);
    return c;
  endfunction

  // a well-formed line built from the current table, now and then corrupted
  task automatic send_line();
    int         pick, n;
    logic [7:0] term;
    term = lines.terminator;
    line_q.delete();
    if ($urandom_range(2) == 0) begin
      line_q.push_back(CHAR_PERCENT);
      n = field_len(DEF_PREFIX_CAP);
      repeat (n) line_q.push_back(text_char(term, CHAR_PERCENT));
      line_q.push_back(CHAR_PERCENT);
    end
    if (lines.table_size() > 0) begin
      pick = $urandom_range(lines.table_size() - 1);
      n = lines.name_length(pick);
      for (int k = 0; k < n && k < 8; k++) line_q.push_back(lines.name_byte(pick, k));
    end
    if ($urandom_range(3) != 0) begin
      line_q.push_back(CHAR_COMMA);
      n = field_len(DEF_PARAM_CAP);
      repeat (n) line_q.push_back(text_char(term, CHAR_COMMA));
      if ($urandom_range(2) != 0) begin
        line_q.push_back(CHAR_COMMA);
        n = field_len(DEF_VALUE_CAP);
        repeat (n) line_q.push_back(text_char(term, term));
      end
    end
    if ($urandom_range(5) == 0 && line_q.size() > 0)
      line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
    line_q.push_back(term);
    foreach (line_q[k]) send_byte(line_q[k]);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n)
      send_byte(($urandom_range(7) == 0) ? lines.terminator : 8'($urandom_range(255)));
  endtask

  task automatic random_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_PER_PHASE) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_line();
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_arm      = 1'b0;
    bytes_sent    = 0;
    set_idle(31, 74);
    lines = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset table: one empty name, newline ends a line
    send_text("\n");                 // bare end: not complete
    send_text("%ab%\n");             // prefix only: ok
    send_text("%abcdefghi\n");       // prefix overflow restarts
    send_text("%ab\n");              // still inside the prefix
    send_byte(8'h00);                // zero byte matches the empty name
    send_text("\n");
    wait_idle();

    // shared prefixes: "set" is shadowed by "setx"; full eight-character name
    apply_table(pack_name("setx"), pack_name("set"), pack_name("go"), pack_name("status12"),
                16'h8234, 3'd4, 8'h0A);
    send_text("go,p1,v9\n");
    send_text("status12\n");
    send_text("set,x\n");
    send_text("setx,,\n");
    send_text("gx\n");
    send_text("go,");
    send_run("p", DEF_PARAM_CAP);
    send_text(",\n");                // comma into a full param field
    send_text("%12345678%status12,");
    send_run("p", DEF_PARAM_CAP - 1);
    send_text(",");
    send_run("v", DEF_VALUE_CAP);
    send_text("\n");                 // longest possible run
    wait_idle();

    set_idle(74, 31);
    foreach (rand_names[i]) rand_names[i] = {$urandom, $urandom};
    apply_table(rand_names[0], rand_names[1], rand_names[2], rand_names[3],
                {4'($urandom_range(15)), 4'($urandom_range(2, 8)),
                 4'($urandom_range(2, 8)), 4'($urandom_range(2, 8))},
                3'd4, 8'hFF);
    write_cfg(CFG_UNUSED, {$urandom, $urandom});
    random_phase();
    wait_idle();

    // empty table, all-ones registers, zero end byte
    apply_table('0, '0, '0, '1, 16'hFFFF, 3'd0, 8'h00);
    write_cfg(CFG_UNUSED, '1);
    random_phase();
    wait_idle();

    // no idling; count above the table size; '%' ends lines
    set_idle(0, 0);
    apply_table(pack_name("setx"), pack_name("set"), pack_name("go"), pack_name("status12"),
                16'h8234, 3'd7, CHAR_PERCENT);
    hold_arm = 1'b1;
    random_phase();
    wait_idle();

    // end byte is the first character of "go", a name beyond the active count
    apply_table(pack_name("setx"), pack_name("set"), pack_name("go"), pack_name("status12"),
                16'h8234, 3'd2, "g");
    send_text("go,abgo,");
    random_phase();
    wait_idle();

    if (lines.errors == 0)
      $display("command_line_stream_parser_unit_tb: clean");
    else
      $display("command_line_stream_parser_unit_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

/* command_line_stream_parser_unit.f */
+incdir+sv
sv/clsp_pkg.sv
sv/clsp_ctrl.sv
sv/clsp_datapath.sv
sv/command_line_stream_parser_unit.sv
sim/command_line_stream_parser_unit_tb.sv
